### hdl/nrp_pkg.sv
`default_nettype none

package nrp_pkg;

  // State bits that take part in the exponent
  localparam int unsigned STATE_BITS = 32;
  localparam int unsigned BIT_IDX_W  = $clog2(STATE_BITS);
  localparam int unsigned TBL_IDX_W  = $clog2(STATE_BITS + 1);

  // Moduli, generator and their bit lengths
  localparam logic [31:0] NR_L   = 32'd9999929;
  localparam logic [31:0] NR_P   = 32'd4279969613;
  localparam logic [31:0] NR_G   = 32'd9999918;
  localparam int unsigned L_BITS = 24;
  localparam int unsigned P_BITS = 32;

  // Barrett constants, floor(2^(2k) / m)
  localparam logic [64:0] MU_L_FULL = (65'd1 << (2 * L_BITS)) / {33'd0, NR_L};
  localparam logic [64:0] MU_P_FULL = (65'd1 << (2 * P_BITS)) / {33'd0, NR_P};
  localparam logic [32:0] MU_L      = MU_L_FULL[32:0];
  localparam logic [32:0] MU_P      = MU_P_FULL[32:0];

  // Remainder width before correction: r < 3m
  localparam int unsigned RW = P_BITS + 3;

  localparam logic [31:0] E_INIT_FULL = 32'd650051 % NR_L;
  localparam logic [L_BITS-1:0] E_INIT = E_INIT_FULL[L_BITS-1:0];

  // Input action codes
  localparam logic ACT_RESEED   = 1'b0;
  localparam logic ACT_GENERATE = 1'b1;

  typedef enum logic {
    MOD_L,
    MOD_P
  } mod_sel_t;

  typedef struct packed {
    logic        start;
    mod_sel_t    sel;
    logic [31:0] a;
    logic [31:0] b;
  } mm_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] res;
  } mm_resp_t;

  function automatic logic [L_BITS-1:0] mult_coef(input logic [TBL_IDX_W-1:0] idx);
    logic [L_BITS-1:0] c;
    unique case (idx)
      6'd0:    c = 24'd650051;
      6'd1:    c = 24'd3948705;
      6'd2:    c = 24'd3142325;
      6'd3:    c = 24'd4036110;
      6'd4:    c = 24'd1141941;
      6'd5:    c = 24'd5739231;
      6'd6:    c = 24'd5725758;
      6'd7:    c = 24'd8299330;
      6'd8:    c = 24'd1776388;
      6'd9:    c = 24'd1423550;
      6'd10:   c = 24'd9260804;
      6'd11:   c = 24'd156410;
      6'd12:   c = 24'd1190436;
      6'd13:   c = 24'd61218;
      6'd14:   c = 24'd2382500;
      6'd15:   c = 24'd1738876;
      6'd16:   c = 24'd7978879;
      6'd17:   c = 24'd6010478;
      6'd18:   c = 24'd310917;
      6'd19:   c = 24'd4280253;
      6'd20:   c = 24'd24724;
      6'd21:   c = 24'd7087659;
      6'd22:   c = 24'd796099;
      6'd23:   c = 24'd8383655;
      6'd24:   c = 24'd7638286;
      6'd25:   c = 24'd1390415;
      6'd26:   c = 24'd7899225;
      6'd27:   c = 24'd5628976;
      6'd28:   c = 24'd1472292;
      6'd29:   c = 24'd4284966;
      6'd30:   c = 24'd9708041;
      6'd31:   c = 24'd4179835;
      6'd32:   c = 24'd3635954;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

### hdl/nrp_mulmod.sv
`default_nettype none

// Shared modular multiplier: one 33x33 multiplier used three times
// (product, Barrett quotient, quotient times modulus), then a correction.
module nrp_mulmod (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire nrp_pkg::mm_req_t req,
  output nrp_pkg::mm_resp_t     resp
);
  import nrp_pkg::*;

  typedef enum logic [1:0] {
    M_IDLE,
    M_QUOT,
    M_REM,
    M_CORR
  } mm_state_t;

  mm_state_t      state_r;
  mod_sel_t       sel_r;
  logic [63:0]    x_r;
  logic [32:0]    q3_r;
  logic [RW-1:0]  r_r;
  logic [31:0]    res_r;
  logic           done_r;

  logic [32:0]    mul_a;
  logic [32:0]    mul_b;
  logic [65:0]    mul_p;
  logic [32:0]    q1;
  logic [32:0]    q3;
  logic [31:0]    m_sel;
  logic [RW-1:0]  m_ext;
  logic [RW-1:0]  m_dbl;
  logic [RW-1:0]  r_corr;

  assign m_sel = (sel_r == MOD_P) ? NR_P : NR_L;
  assign q1    = (sel_r == MOD_P) ? 33'(x_r >> (P_BITS - 1)) : 33'(x_r >> (L_BITS - 1));
  assign q3    = (sel_r == MOD_P) ? 33'(mul_p >> (P_BITS + 1)) : 33'(mul_p >> (L_BITS + 1));

  always_comb begin
    unique case (state_r)
      M_IDLE: begin
        mul_a = {1'b0, req.a};
        mul_b = {1'b0, req.b};
      end
      M_QUOT: begin
        mul_a = q1;
        mul_b = (sel_r == MOD_P) ? MU_P : MU_L;
      end
      M_REM: begin
        mul_a = q3_r;
        mul_b = {1'b0, m_sel};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = 66'(mul_a) * 66'(mul_b);

  // Barrett leaves r below 3m
  assign m_ext  = RW'(m_sel);
  assign m_dbl  = m_ext << 1;
  assign r_corr = (r_r >= m_dbl) ? (r_r - m_dbl) :
                  (r_r >= m_ext) ? (r_r - m_ext) : r_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        M_IDLE: begin
          if (req.start) begin
            x_r     <= mul_p[63:0];
            sel_r   <= req.sel;
            state_r <= M_QUOT;
          end
        end
        M_QUOT: begin
          q3_r    <= q3;
          state_r <= M_REM;
        end
        M_REM: begin
          r_r     <= x_r[RW-1:0] - mul_p[RW-1:0];
          state_r <= M_CORR;
        end
        M_CORR: begin
          res_r   <= r_corr[31:0];
          done_r  <= 1'b1;
          state_r <= M_IDLE;
        end
        default: state_r <= M_IDLE;
      endcase
    end
  end

  assign resp.done = done_r;
  assign resp.res  = res_r;

endmodule

`default_nettype wire

### hdl/naor_reingold_prng.sv
// Channel   Direction  Handshake             Beat
// in        input      in_valid / in_ready   in_action, in_seed
// out       output     out_valid / out_ready out_random_value
// cfg       input      cfg_valid / cfg_ready cfg_data (fallback seed)
//
// Reseed: taken in S_IDLE without leaving it, so in_ready stays high.
// Generate: the exponent is built over the STATE_BITS state bits, one
// modular product per set bit, then g^e mod p by square-and-multiply;
// each modular product runs in turn on the shared multiplier.
// A finished value waits in the output register; the next beat is taken
// meanwhile. Synchronous active-low reset: state and fallback seed to 1.
`default_nettype none

module naor_reingold_prng (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_action,
  input  wire logic [31:0] in_seed,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_random_value,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data
);
  import nrp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXP,
    S_EXP_WAIT,
    S_POW_INIT,
    S_POW,
    S_POW_MWAIT,
    S_POW_SWAIT,
    S_OUT
  } state_t;

  state_t                 state_r;
  logic [31:0]            state_val_r;
  logic [31:0]            fallback_r;
  logic [L_BITS-1:0]      e_r;
  logic [L_BITS-1:0]      ex_r;
  logic [BIT_IDX_W-1:0]   bit_r;
  logic [31:0]            acc_r;
  logic [31:0]            sq_r;
  logic [31:0]            out_value_r;
  logic                   out_valid_r;

  mm_req_t                mm_req;
  mm_resp_t               mm_resp;
  logic [TBL_IDX_W-1:0]   tbl_idx;
  logic                   last_bit;

  assign tbl_idx  = TBL_IDX_W'(bit_r) + TBL_IDX_W'(1);
  assign last_bit = (bit_r == BIT_IDX_W'(STATE_BITS - 1));

  always_comb begin
    mm_req.start = 1'b0;
    mm_req.sel   = MOD_L;
    mm_req.a     = '0;
    mm_req.b     = '0;
    unique case (state_r)
      S_EXP: begin
        mm_req.start = state_val_r[bit_r];
        mm_req.a     = 32'(e_r);
        mm_req.b     = 32'(mult_coef(tbl_idx));
      end
      S_POW: begin
        // odd exponent: fold square into acc, else square
        mm_req.start = (ex_r != '0);
        mm_req.sel   = MOD_P;
        mm_req.a     = ex_r[0] ? acc_r : sq_r;
        mm_req.b     = sq_r;
      end
      default: ;
    endcase
  end

  nrp_mulmod u_mulmod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mm_req),
    .resp  (mm_resp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      state_val_r <= 32'd1;
      fallback_r  <= 32'd1;
    end else begin
      if (cfg_valid && cfg_ready) begin
        fallback_r <= cfg_data;
      end
      // S_OUT reloads the register itself
      if (out_valid_r && out_ready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            if (in_action == ACT_GENERATE) begin
              e_r     <= E_INIT;
              bit_r   <= '0;
              state_r <= S_EXP;
            end else begin
              state_val_r <= (in_seed != 32'd0) ? in_seed : fallback_r;
            end
          end
        end
        S_EXP: begin
          if (state_val_r[bit_r]) begin
            state_r <= S_EXP_WAIT;
          end else if (last_bit) begin
            state_r <= S_POW_INIT;
          end else begin
            bit_r <= bit_r + BIT_IDX_W'(1);
          end
        end
        S_EXP_WAIT: begin
          if (mm_resp.done) begin
            e_r <= mm_resp.res[L_BITS-1:0];
            if (last_bit) begin
              state_r <= S_POW_INIT;
            end else begin
              bit_r   <= bit_r + BIT_IDX_W'(1);
              state_r <= S_EXP;
            end
          end
        end
        S_POW_INIT: begin
          acc_r   <= 32'd1;
          sq_r    <= NR_G;
          ex_r    <= e_r;
          state_r <= S_POW;
        end
        S_POW: begin
          if (ex_r == '0) begin
            state_r <= S_OUT;
          end else if (ex_r[0]) begin
            state_r <= S_POW_MWAIT;
          end else begin
            state_r <= S_POW_SWAIT;
          end
        end
        S_POW_MWAIT: begin
          if (mm_resp.done) begin
            acc_r   <= mm_resp.res;
            ex_r[0] <= 1'b0;
            state_r <= S_POW;
          end
        end
        S_POW_SWAIT: begin
          if (mm_resp.done) begin
            sq_r    <= mm_resp.res;
            ex_r    <= ex_r >> 1;
            state_r <= S_POW;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_value_r <= acc_r;
            out_valid_r <= 1'b1;
            state_val_r <= acc_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready         = (state_r == S_IDLE);
  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_random_value = out_value_r;

endmodule

`default_nettype wire

### hdl/nrp_checker.sv
`default_nettype none

module nrp_props (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        in_action,
  input wire logic [31:0] in_seed,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_random_value,
  input wire logic        cfg_valid,
  input wire logic        cfg_ready,
  input wire logic [31:0] cfg_data
);
  import nrp_pkg::*;

  // a held result beat stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_random_value))
    else $error("out beat changed while stalled");

  // g^e mod p lies in 1..p-1
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_random_value != 32'd0) && (out_random_value < NR_P))
    else $error("out value outside 1..p-1");

  // generate keeps the block busy
  a_gen_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_action == ACT_GENERATE) |=> !in_ready)
    else $error("in_ready high right after a generate beat");

  // reseed gives no result
  a_reseed_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_action == ACT_RESEED) |=> !$rose(out_valid))
    else $error("result after a reseed beat");

  // a new result only comes out of a busy period
  a_out_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while idle");

endmodule

bind naor_reingold_prng nrp_props u_nrp_checker (.*);

`default_nettype wire

### bench/nrp_checker.sv
`default_nettype none

module nrp_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic        in_action,
  input  wire logic [31:0] in_seed,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [31:0] out_random_value,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [31:0] cfg_data,
  output int unsigned      n_waiting,
  output int unsigned      n_errors
);

  import nrp_pkg::*;

  localparam logic [31:0] EXP_MOD   = 32'd9999929;
  localparam logic [31:0] PRIME     = 32'd4279969613;
  localparam logic [31:0] GEN       = 32'd9999918;
  localparam int unsigned NUM_BITS  = 32;
  localparam int unsigned MAX_SHOWN = 10;

  // exponent coefficients, entry 32 first so that entry k sits at [24*k +: 24]
  localparam logic [33*24-1:0] COEFS = {
    24'd3635954, 24'd4179835, 24'd9708041, 24'd4284966, 24'd1472292, 24'd5628976,
    24'd7899225, 24'd1390415, 24'd7638286, 24'd8383655, 24'd796099,  24'd7087659,
    24'd24724,   24'd4280253, 24'd310917,  24'd6010478, 24'd7978879, 24'd1738876,
    24'd2382500, 24'd61218,   24'd1190436, 24'd156410,  24'd9260804, 24'd1423550,
    24'd1776388, 24'd8299330, 24'd5725758, 24'd5739231, 24'd1141941, 24'd4036110,
    24'd3142325, 24'd3948705, 24'd650051
  };

  logic [31:0] gen_state;
  logic [31:0] fallback;
  logic [31:0] value_q[$];

  function automatic logic [31:0] mod_mul(logic [31:0] a, logic [31:0] b, logic [31:0] m);
    logic [63:0] prod;
    prod = {32'd0, a} * {32'd0, b};
    return 32'(prod % {32'd0, m});
  endfunction

  function automatic logic [31:0] mod_pow(logic [31:0] base, logic [31:0] ex, logic [31:0] m);
    logic [31:0] acc;
    logic [31:0] sq;
    acc = 32'd1 % m;
    sq  = base % m;
    while (ex != 32'd0) begin
      if (ex[0])
        acc = mod_mul(acc, sq, m);
      sq = mod_mul(sq, sq, m);
      ex = ex >> 1;
    end
    return acc;
  endfunction

  // next generator value from state x
  function automatic logic [31:0] nr_next(logic [31:0] x);
    logic [31:0] e;
    e = {8'd0, COEFS[23:0]} % EXP_MOD;
    for (int i = 0; i < NUM_BITS; i++) begin
      if (x[i])
        e = mod_mul(e, {8'd0, COEFS[24*(i+1) +: 24]}, EXP_MOD);
    end
    return mod_pow(GEN, e, PRIME);
  endfunction

  always @(posedge clk) begin
    logic [31:0] want;
    if (!rst_n) begin
      gen_state = 32'd1;
      fallback  = 32'd1;
      value_q.delete();
      n_waiting = 0;
      n_errors  = 0;
    end else begin
      if (cfg_valid && cfg_ready)
        fallback = cfg_data;
      // pop before push: a beat taken this edge cannot already be answered
      if (out_valid && out_ready) begin
        if (value_q.size() == 0) begin
          if (n_errors < MAX_SHOWN)
            $display("unexpected out beat: random_value %h", out_random_value);
          n_errors++;
        end else begin
          want = value_q.pop_front();
          if (out_random_value !== want) begin
            if (n_errors < MAX_SHOWN)
              $display("random_value mismatch: expected %h got %h", want, out_random_value);
            n_errors++;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (in_action == ACT_RESEED) begin
          gen_state = (in_seed != 32'd0) ? in_seed : fallback;
        end else begin
          gen_state = nr_next(gen_state);
          value_q.push_back(gen_state);
        end
      end
      n_waiting = value_q.size();
    end
  end

endmodule

`default_nettype wire

### bench/tb_naor_reingold_prng.sv
`default_nettype none

module tb_naor_reingold_prng;

  import nrp_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 5_000_000;
  localparam int unsigned PHASE_ITEMS  = 205;
  localparam int unsigned SETTLE       = 8;
  localparam int unsigned TAIL         = 60;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_action;
  logic [31:0] in_seed;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_random_value;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;
  int unsigned n_waiting;
  int unsigned n_errors;
  int unsigned cycles = 0;
  bit          quiet = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  naor_reingold_prng u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_seed          (in_seed),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_random_value (out_random_value),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  nrp_checker u_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_seed          (in_seed),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_random_value (out_random_value),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .n_waiting        (n_waiting),
    .n_errors         (n_errors)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50)
      return 0;
    else if (r < 90)
      return $urandom_range(1, 3);
    else
      return $urandom_range(10, 80);
  endfunction

  function automatic logic [31:0] pick_seed();
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1:       return 32'd1 << $urandom_range(0, 31);
      2:       return ~(32'd1 << $urandom_range(0, 31));
      3:       return 32'hFFFF_FFFF;
      4:       return $urandom & $urandom;
      default: return $urandom;
    endcase
  endfunction

  // receiver stalls
  initial begin
    int unsigned gap;
    forever begin
      out_ready = 1'b1;
      repeat ($urandom_range(1, 20)) @(negedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        out_ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  end

  // all tasks are entered and left at a falling edge
  task automatic send_beat(logic act, logic [31:0] sd);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  = 1'b1;
    in_action = act;
    in_seed   = sd;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (n_waiting != 0) @(negedge clk);
    // a trailing reseed may still be in flight
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_fallback(logic [31:0] v);
    drain();
    cfg_valid = 1'b1;
    cfg_data  = v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic run_phase(logic [31:0] fb);
    int unsigned sent;
    int unsigned n;
    write_fallback(fb);
    sent = 0;
    while (sent < PHASE_ITEMS) begin
      if ($urandom_range(0, 9) < 8) begin
        n = $urandom_range(1, 5);
        send_beat(ACT_RESEED, pick_seed());
        repeat (n) send_beat(ACT_GENERATE, $urandom);
        sent += n + 1;
      end else begin
        send_beat(1'($urandom_range(0, 1)), $urandom);
        sent++;
      end
      if ($urandom_range(0, 49) == 0)
        drain();
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_action = ACT_RESEED;
    in_seed   = 32'd0;
    cfg_valid = 1'b0;
    cfg_data  = 32'd0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: reset state, zero seed, extremes of the state
    send_beat(ACT_GENERATE, 32'd0);
    send_beat(ACT_RESEED, 32'd0);
    send_beat(ACT_GENERATE, 32'd0);
    send_beat(ACT_RESEED, 32'hFFFF_FFFF);
    send_beat(ACT_GENERATE, 32'hFFFF_FFFF);
    send_beat(ACT_GENERATE, 32'd0);
    send_beat(ACT_RESEED, 32'h8000_0000);
    send_beat(ACT_GENERATE, 32'd0);
    send_beat(ACT_RESEED, 32'h5555_5555);
    send_beat(ACT_GENERATE, 32'hAAAA_AAAA);
    // fallback of zero gives state zero, exponent a0 alone
    write_fallback(32'd0);
    send_beat(ACT_RESEED, 32'd0);
    send_beat(ACT_GENERATE, 32'd0);
    write_fallback(32'hFFFF_FFFF);
    send_beat(ACT_RESEED, 32'd0);
    send_beat(ACT_GENERATE, 32'd0);
    write_fallback($urandom);
    send_beat(ACT_RESEED, 32'd0);
    send_beat(ACT_GENERATE, 32'd0);
    send_beat(ACT_GENERATE, 32'd0);
    send_beat(ACT_RESEED, 32'hAAAA_AAAA);
    send_beat(ACT_GENERATE, 32'd0);

    run_phase(32'd1);
    run_phase(32'hFFFF_FFFF);
    run_phase(32'd0);
    quiet = 1'b1;
    run_phase($urandom);
    quiet = 1'b0;
    run_phase($urandom);
    run_phase(32'h8000_0000);
    run_phase(32'd1);

    drain();
    repeat (TAIL) @(negedge clk);
    if (n_errors == 0 && n_waiting == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

`default_nettype wire
